[src/lfu_pkg.sv]
// Shared types and constants for the LFU cache with LRU tie break.
// No dependencies; imported by the cache top level.
package lfu_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int USE_W  = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;   // -1 on a get miss
    localparam logic [USE_W-1:0]  USE_MAX    = '1;   // use count saturates here
    localparam logic [USE_W-1:0]  USE_FIRST  = 32'd1;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

endpackage

[src/lfu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/lfu_cache_lru_tiebreak_unit.sv]
// LFU key-value cache top level; state in one lfu_ram instance.
// Depends on lfu_pkg and lfu_ram.
//
// Fully associative key-value cache of ENTRIES slots with least-frequently-used
// replacement; ties on use count go to the least recently used entry. Requests
// arrive on the s_axis side (tuser = command, get or set); each get returns one
// result on the m_axis side (tuser = hit, tdata = value or -1 on a miss), a set
// returns nothing. Key, value, use count and recency rank of every slot live in
// one RAM word; only the per-slot valid bits and the fill count are flops, so
// there is no clearing pass after reset. Each request walks the RAM once to
// find the key, the eviction victim and the first free slot (one read per
// cycle), takes a decision step, which a get holds until the previous result
// has left, and, on a hit or a set, walks the RAM a second time to rewrite
// ranks and counts, reading slot i while writing slot i-1. The next request
// is taken while a get result still waits in the output register. capacity
// is written through cfg_wr_en/cfg_wr_data; the user must do so only while
// idle, as the block itself does not enforce it. Zero acts as one and values
// above ENTRIES act as ENTRIES.
module lfu_cache_lru_tiebreak_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // config
    input  logic                                        cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0]                   cfg_wr_data,   // capacity
    // request stream
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  logic [lfu_pkg::KEY_W+lfu_pkg::DATA_W-1:0]   s_axis_tdata,  // key, write_value
    input  logic                                        s_axis_tuser,  // cmd
    // result stream
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    output logic [lfu_pkg::DATA_W-1:0]                  m_axis_tdata,  // read_value
    output logic                                        m_axis_tuser   // hit
);

    import lfu_pkg::*;

    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    // RAM word: {key, data, use count, rank}
    localparam int USE_LSB  = IDX_W;
    localparam int DATA_LSB = USE_LSB + USE_W;
    localparam int KEY_LSB  = DATA_LSB + DATA_W;
    localparam int WORD_W   = KEY_LSB + KEY_W;

    // control
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic                match_found_reg, match_found_next;
    logic                vic_found_reg, vic_found_next;
    logic                free_found_reg, free_found_next;
    logic                out_valid_reg, out_valid_next;

    // request payload and scan results
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]   wval_reg, wval_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]    match_rank_reg, match_rank_next;
    logic [DATA_W-1:0]   match_data_reg, match_data_next;
    logic [IDX_W-1:0]    vic_idx_reg, vic_idx_next;
    logic [USE_W-1:0]    vic_use_reg, vic_use_next;
    logic [IDX_W-1:0]    vic_rank_reg, vic_rank_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;

    // update pass setup
    logic [IDX_W-1:0]    spec_idx_reg, spec_idx_next;   // slot touched or inserted
    logic [IDX_W-1:0]    thr_rank_reg, thr_rank_next;   // ranks above this move down
    logic                dec_en_reg, dec_en_next;
    logic                ins_mode_reg, ins_mode_next;
    logic [IDX_W-1:0]    new_rank_reg, new_rank_next;

    // output register
    logic                out_hit_reg, out_hit_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;

    // RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [WORD_W-1:0]   ram_rdata;

    // helpers
    logic [CNT_W-1:0]    proc_cnt;
    logic [IDX_W-1:0]    proc_idx;
    logic                proc_vld;
    logic                last;
    logic                e_valid;
    logic [KEY_W-1:0]    rd_key;
    logic [DATA_W-1:0]   rd_data;
    logic [USE_W-1:0]    rd_use;
    logic [IDX_W-1:0]    rd_rank;
    logic [USE_W-1:0]    use_inc;
    logic [31:0]         cap_eff;
    logic                evict;
    logic [IDX_W-1:0]    ins_idx;
    logic [CNT_W-1:0]    fill_after;
    logic [CNT_W-1:0]    rank_top;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[KEY_LSB +: KEY_W];
    assign rd_data  = ram_rdata[DATA_LSB +: DATA_W];
    assign rd_use   = ram_rdata[USE_LSB +: USE_W];
    assign rd_rank  = ram_rdata[IDX_W-1:0];
    assign use_inc  = (rd_use == USE_MAX) ? rd_use : rd_use + USE_W'(1);

    // slot whose RAM word arrives this cycle
    assign proc_cnt = cnt_reg - CNT_W'(1);
    assign proc_idx = proc_cnt[IDX_W-1:0];
    assign proc_vld = (cnt_reg != '0);
    assign last     = (cnt_reg == CNT_W'(ENTRIES));
    assign e_valid  = valid_reg[proc_idx];

    assign ram_re   = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) && !last;
    assign ram_waddr = proc_idx;

    // effective capacity: zero acts as one, clamp to slot count
    always_comb
    begin
        cap_eff = 32'(cap_reg);
        if (cap_eff == 32'd0)
        begin
            cap_eff = 32'd1;
        end
        else if (cap_eff > 32'(ENTRIES))
        begin
            cap_eff = 32'(ENTRIES);
        end
    end

    assign evict = (32'(fill_reg) >= cap_eff);

    // after an eviction the lowest free slot may be the victim itself
    always_comb
    begin
        if (!evict)
        begin
            ins_idx = free_idx_reg;
        end
        else if (free_found_reg && (free_idx_reg < vic_idx_reg))
        begin
            ins_idx = free_idx_reg;
        end
        else
        begin
            ins_idx = vic_idx_reg;
        end
    end

    assign fill_after = (cmd_reg == CMD_SET && !match_found_reg && !evict)
                        ? fill_reg + CNT_W'(1) : fill_reg;
    assign rank_top   = fill_after - CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        valid_next       = valid_reg;
        fill_next        = fill_reg;
        cap_next         = cfg_wr_en ? cfg_wr_data : cap_reg;
        match_found_next = match_found_reg;
        vic_found_next   = vic_found_reg;
        free_found_next  = free_found_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        wval_next        = wval_reg;
        match_idx_next   = match_idx_reg;
        match_rank_next  = match_rank_reg;
        match_data_next  = match_data_reg;
        vic_idx_next     = vic_idx_reg;
        vic_use_next     = vic_use_reg;
        vic_rank_next    = vic_rank_reg;
        free_idx_next    = free_idx_reg;
        spec_idx_next    = spec_idx_reg;
        thr_rank_next    = thr_rank_reg;
        dec_en_next      = dec_en_reg;
        ins_mode_next    = ins_mode_reg;
        new_rank_next    = new_rank_reg;
        out_hit_next     = out_hit_reg;
        out_data_next    = out_data_reg;
        ram_we           = 1'b0;
        ram_wdata        = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next         = cmd_t'(s_axis_tuser);
                    key_next         = s_axis_tdata[KEY_W-1:0];
                    wval_next        = s_axis_tdata[KEY_W +: DATA_W];
                    match_found_next = 1'b0;
                    vic_found_next   = 1'b0;
                    free_found_next  = 1'b0;
                    cnt_next         = '0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (proc_vld)
                begin
                    if (e_valid && !match_found_reg && (rd_key == key_reg))
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = proc_idx;
                        match_rank_next  = rd_rank;
                        match_data_next  = rd_data;
                    end
                    // victim: lowest count, then oldest
                    if (e_valid && (!vic_found_reg || (rd_use < vic_use_reg) ||
                        ((rd_use == vic_use_reg) && (rd_rank < vic_rank_reg))))
                    begin
                        vic_found_next = 1'b1;
                        vic_idx_next   = proc_idx;
                        vic_use_next   = rd_use;
                        vic_rank_next  = rd_rank;
                    end
                    if (!e_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx;
                    end
                end
                if (last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DECIDE:
            begin
                cnt_next      = '0;
                new_rank_next = rank_top[IDX_W-1:0];
                if (cmd_reg == CMD_GET)
                begin
                    // hold until the previous result has left
                    if (!(out_valid_reg && !m_axis_tready))
                    begin
                        out_valid_next = 1'b1;
                        out_hit_next   = match_found_reg;
                        out_data_next  = match_found_reg ? match_data_reg : MISS_VALUE;
                        spec_idx_next  = match_idx_reg;
                        thr_rank_next  = match_rank_reg;
                        dec_en_next    = 1'b1;
                        ins_mode_next  = 1'b0;
                        state_next     = match_found_reg ? ST_UPDATE : ST_IDLE;
                    end
                end
                else if (match_found_reg)
                begin
                    spec_idx_next = match_idx_reg;
                    thr_rank_next = match_rank_reg;
                    dec_en_next   = 1'b1;
                    ins_mode_next = 1'b0;
                    state_next    = ST_UPDATE;
                end
                else
                begin
                    if (evict)
                    begin
                        valid_next[vic_idx_reg] = 1'b0;
                    end
                    valid_next[ins_idx] = 1'b1;
                    fill_next     = fill_after;
                    spec_idx_next = ins_idx;
                    thr_rank_next = vic_rank_reg;
                    dec_en_next   = evict;
                    ins_mode_next = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (proc_vld)
                begin
                    if (proc_idx == spec_idx_reg)
                    begin
                        ram_we = 1'b1;
                        if (ins_mode_reg)
                        begin
                            ram_wdata = {key_reg, wval_reg, USE_FIRST, new_rank_reg};
                        end
                        else
                        begin
                            ram_wdata = {rd_key,
                                         (cmd_reg == CMD_SET) ? wval_reg : rd_data,
                                         use_inc, new_rank_reg};
                        end
                    end
                    else if (e_valid && dec_en_reg && (rd_rank > thr_rank_reg))
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_key, rd_data, rd_use, rd_rank - IDX_W'(1)};
                    end
                end
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            valid_reg       <= '0;
            fill_reg        <= '0;
            cap_reg         <= CAP_RESET;
            match_found_reg <= 1'b0;
            vic_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            valid_reg       <= valid_next;
            fill_reg        <= fill_next;
            cap_reg         <= cap_next;
            match_found_reg <= match_found_next;
            vic_found_reg   <= vic_found_next;
            free_found_reg  <= free_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        wval_reg       <= wval_next;
        match_idx_reg  <= match_idx_next;
        match_rank_reg <= match_rank_next;
        match_data_reg <= match_data_next;
        vic_idx_reg    <= vic_idx_next;
        vic_use_reg    <= vic_use_next;
        vic_rank_reg   <= vic_rank_next;
        free_idx_reg   <= free_idx_next;
        spec_idx_reg   <= spec_idx_next;
        thr_rank_reg   <= thr_rank_next;
        dec_en_reg     <= dec_en_next;
        ins_mode_reg   <= ins_mode_next;
        new_rank_reg   <= new_rank_next;
        out_hit_reg    <= out_hit_next;
        out_data_reg   <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = out_data_reg;

    // fill count tracks the valid bits
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(fill_reg))
        else $error("fill count does not match valid bits");

    // RAM is only written during the update pass
    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_UPDATE))
        else $error("RAM write outside update pass");

    // a result appears only from the decision step of a get
    a_result_from_get: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DECIDE && cmd_reg == CMD_GET))
        else $error("result without a get");

endmodule
